// ===== hdl/barometric_sensor_compensation_assert.svh =====
// Assertion shorthands shared by the compensation RTL.
// Both expect clk in scope; BSC_ASSERT also expects rst_n.
`ifndef BAROMETRIC_SENSOR_COMPENSATION_ASSERT_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_ASSERT_SVH

// Checked only while out of reset.
`define BSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define BSC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/bsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bsc_pkg;

    localparam int unsigned IN_TDATA_W  = 56;
    localparam int unsigned OUT_TDATA_W = 120;
    localparam int unsigned HUM_W       = 17;
    localparam int unsigned CFG_W       = 64;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned DIV_STEPS   = 64;
    localparam int unsigned PIPE_DEPTH  = 84;

    localparam logic [63:0] T_OFFSET_P = 64'd128000;
    localparam logic [63:0] P_BASE     = 64'd1048576;
    localparam logic [63:0] P_SCALE    = 64'd3125;
    localparam logic [63:0] P_ONE47    = 64'h0000_8000_0000_0000;
    localparam logic [31:0] T_RND      = 32'd128;
    localparam logic [31:0] T_OFFSET_H = 32'd76800;
    localparam logic [31:0] H_RND_F1   = 32'd16384;
    localparam logic [31:0] H_BIAS_F2  = 32'd2097152;
    localparam logic [31:0] H_BIAS_I2  = 32'd32768;
    localparam logic [31:0] H_RND_F2   = 32'd8192;
    localparam logic [31:0] HUM_MAX    = 32'd419430400;
    localparam logic [HUM_W-1:0] HUM_OUT_MAX = 17'd102400;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HAS_HUM   = 3'd0,
        CFG_TEMP      = 3'd1,
        CFG_PRESS_A   = 3'd2,
        CFG_PRESS_B   = 3'd3,
        CFG_PRESS_HUM = 3'd4,
        CFG_HUM       = 3'd5
    } bsc_cfg_idx_t;

    // Results that ride alongside the pressure division
    typedef struct packed {
        logic             press_ok;
        logic [HUM_W-1:0] hum;
        logic [31:0]      temp_centi;
        logic [31:0]      fine;
    } bsc_side_t;

    function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [31:0] sx8_32(input logic [7:0] x);
        return {{24{x[7]}}, x};
    endfunction

    function automatic logic [31:0] sx12_32(input logic [11:0] x);
        return {{20{x[11]}}, x};
    endfunction

    function automatic logic [31:0] sx16_32(input logic [15:0] x);
        return {{16{x[15]}}, x};
    endfunction

    function automatic logic [63:0] sx16_64(input logic [15:0] x);
        return {{48{x[15]}}, x};
    endfunction

    function automatic logic [63:0] sx32_64(input logic [31:0] x);
        return {{32{x[31]}}, x};
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bsc_mul64.sv =====
`timescale 1ns / 1ps
`default_nettype none

// 64 x 64 product modulo 2^64 from three 32 x 32 partial products.
// Two register stages: partials, then the sum.
module bsc_mul64 (
    input  wire         clk,
    input  wire         en,
    input  wire  [63:0] a,
    input  wire  [63:0] b,
    output logic [63:0] p
);
    logic [63:0] ll_reg;
    logic [31:0] lh_reg;
    logic [31:0] hl_reg;
    logic [63:0] p_reg;

    logic [63:0] ll_next;
    logic [31:0] lh_next;
    logic [31:0] hl_next;
    logic [31:0] cross_sum;

    always_comb
    begin
        ll_next   = 64'(a[31:0]) * 64'(b[31:0]);
        lh_next   = a[31:0] * b[63:32];
        hl_next   = a[63:32] * b[31:0];
        cross_sum = lh_reg + hl_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= ll_next;
            lh_reg <= lh_next;
            hl_reg <= hl_next;
            p_reg  <= ll_reg + {cross_sum, 32'b0};
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ===== hdl/bsc_div64.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Signed 64-bit division, truncating toward zero, one restoring step per stage.
// Stages: operand stage, DIV_STEPS step stages, sign stage.
module bsc_div64 (
    input  wire                      clk,
    input  wire                      en,
    input  wire  [63:0]              num,
    input  wire  [63:0]              den,
    input  wire  bsc_pkg::bsc_side_t side_in,
    output logic [63:0]              quot,
    output bsc_pkg::bsc_side_t       side_out
);
    import bsc_pkg::*;

    // {partial remainder, remaining dividend / quotient bits}
    logic [127:0] rq_reg   [0:DIV_STEPS];
    logic [63:0]  d_reg    [0:DIV_STEPS-1];
    logic         neg_reg  [0:DIV_STEPS];
    bsc_side_t    side_reg [0:DIV_STEPS];
    logic [63:0]  quot_reg;
    bsc_side_t    side_out_reg;

    logic [127:0] rq_next [1:DIV_STEPS];
    logic [127:0] sh      [1:DIV_STEPS];
    logic [63:0]  diff    [1:DIV_STEPS];
    logic [63:0]  num_abs;
    logic [63:0]  den_abs;
    logic [63:0]  q_mag;

    always_comb
    begin
        num_abs = num[63] ? 64'(0) - num : num;
        den_abs = den[63] ? 64'(0) - den : den;
        for (int k = 1; k <= DIV_STEPS; k++)
        begin
            sh[k]   = {rq_reg[k-1][126:0], 1'b0};
            diff[k] = sh[k][127:64] - d_reg[k-1];
            if (sh[k][127:64] >= d_reg[k-1])
            begin
                rq_next[k] = {diff[k], sh[k][63:1], 1'b1};
            end
            else
            begin
                rq_next[k] = sh[k];
            end
        end
        q_mag = rq_reg[DIV_STEPS][63:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rq_reg[0]   <= {64'b0, num_abs};
            d_reg[0]    <= den_abs;
            neg_reg[0]  <= num[63] ^ den[63];
            side_reg[0] <= side_in;
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                rq_reg[k]   <= rq_next[k];
                neg_reg[k]  <= neg_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
            for (int k = 1; k < DIV_STEPS; k++)
            begin
                d_reg[k] <= d_reg[k-1];
            end
            quot_reg     <= neg_reg[DIV_STEPS] ? 64'(0) - q_mag : q_mag;
            side_out_reg <= side_reg[DIV_STEPS];
        end
    end

    assign quot     = quot_reg;
    assign side_out = side_out_reg;

endmodule

`default_nettype wire

// ===== hdl/barometric_sensor_compensation.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "barometric_sensor_compensation_assert.svh"

// Integer compensation of a combined pressure / temperature / humidity sensor.
// Input stream: one transaction carries raw pressure, temperature and humidity.
// Output stream: one transaction per input carries fine temperature, temperature
// in hundredths of a degree, pressure (Q24.8 Pa) and humidity (Q7.10 %), with
// tuser flagging a usable pressure (low when the pressure divisor was zero).
// Calibration words and the humidity enable sit in registers written through the
// cfg port; write them only while no transaction is in flight.
// Throughput: one transaction per clock while the skid register is empty. The
// pipeline depth is set by the divider's 64 step stages (one quotient bit per
// stage) plus the multiply stages around it.
// Reset clears the calibration registers, the valid bits of every stage and
// the output and skid valid flags; no clearing pass is needed.
// A stall on m_axis_tready freezes the pipeline only once the one-entry skid
// register behind the output register is occupied, so one more transaction
// still drains out while a result waits. Nothing is dropped or repeated.
module barometric_sensor_compensation (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // raw_pressure[19:0], raw_temperature[39:20], raw_humidity[55:40]
    input  wire  [bsc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // fine_temperature[31:0], temperature_centi[63:32], pressure_q24_8[95:64],
    // humidity_q7_10[112:96], zero pad [119:113]
    output logic [bsc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // pressure_valid[0]
    output logic                               m_axis_tuser,
    input  wire                                cfg_wr_en,
    input  wire  [bsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [bsc_pkg::CFG_W-1:0]          cfg_data
);
    import bsc_pkg::*;

    // ---------------- configuration registers ----------------
    logic        has_hum_reg;
    logic [47:0] temp_calib_reg;
    logic [63:0] press_a_reg;
    logic [63:0] press_b_reg;
    logic [47:0] press_hum_reg;
    logic [31:0] hum_calib_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_hum_reg    <= 1'b0;
            temp_calib_reg <= '0;
            press_a_reg    <= '0;
            press_b_reg    <= '0;
            press_hum_reg  <= '0;
            hum_calib_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_HAS_HUM:   has_hum_reg    <= cfg_data[0];
                CFG_TEMP:      temp_calib_reg <= cfg_data[47:0];
                CFG_PRESS_A:   press_a_reg    <= cfg_data;
                CFG_PRESS_B:   press_b_reg    <= cfg_data;
                CFG_PRESS_HUM: press_hum_reg  <= cfg_data[47:0];
                CFG_HUM:       hum_calib_reg  <= cfg_data[31:0];
                default:       ; // drop writes beyond the register list
            endcase
        end
    end

    // ---------------- calibration word decode ----------------
    logic [31:0] t1, t2, t3;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;

    always_comb
    begin
        t1 = {16'b0, temp_calib_reg[15:0]};
        t2 = sx16_32(temp_calib_reg[31:16]);
        t3 = sx16_32(temp_calib_reg[47:32]);
        p1 = {48'b0, press_a_reg[15:0]};
        p2 = sx16_64(press_a_reg[31:16]);
        p3 = sx16_64(press_a_reg[47:32]);
        p4 = sx16_64(press_a_reg[63:48]);
        p5 = sx16_64(press_b_reg[15:0]);
        p6 = sx16_64(press_b_reg[31:16]);
        p7 = sx16_64(press_b_reg[47:32]);
        p8 = sx16_64(press_b_reg[63:48]);
        p9 = sx16_64(press_hum_reg[15:0]);
        h1 = {24'b0, press_hum_reg[23:16]};
        h2 = sx16_32(press_hum_reg[39:24]);
        h3 = {24'b0, press_hum_reg[47:40]};
        // 12-bit words are sign-extended
        h4 = sx12_32(hum_calib_reg[11:0]);
        h5 = sx12_32(hum_calib_reg[23:12]);
        h6 = sx8_32(hum_calib_reg[31:24]);
    end

    // output and skid register state, shared with the pipeline control
    logic                   out_valid_reg, out_valid_next;
    logic                   skid_valid_reg, skid_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, skid_data_reg;
    logic                   out_user_reg, skid_user_reg;
    logic                   load_out, load_skid, out_from_skid;

    // ---------------- pipeline control ----------------
    logic                  en;
    logic                  take;
    logic [PIPE_DEPTH:1]   vld_reg;

    // Advance every stage together unless the skid register is holding a result.
    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;
    assign take          = en && vld_reg[PIPE_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-1:1], s_axis_tvalid};
        end
    end

    // ---------------- payload stage registers ----------------
    logic [19:0] rp_reg [1:10];
    logic [15:0] rh_reg [1:4];
    logic [19:0] s1_rt_reg;
    logic [31:0] s2_xt2_reg, s2_yy_reg;
    logic [31:0] s3_v1_reg, s3_m_reg;
    logic [31:0] tf_reg [4:13];
    logic [31:0] tc_reg [5:13];
    logic [63:0] s5_a_reg;
    logic [31:0] s5_h5v_reg, s5_i1p_reg, s5_i2p_reg, s5_c_reg;
    logic [31:0] f1_reg [6:9];
    logic [31:0] s6_i1_reg, s6_i2_reg;
    logic [31:0] s7_i12_reg;
    logic [31:0] s8_th2_reg;
    logic [31:0] s9_f2_reg;
    logic [31:0] s10_v2_reg;
    logic [31:0] s11_ss_reg, s11_v2_reg;
    logic [31:0] s12_m_reg, s12_v2_reg;
    logic [HUM_W-1:0] s13_hum_reg;
    logic [63:0] ap5_reg [8:9];
    logic [63:0] ap2_reg [8:9];
    logic [63:0] s10_b_reg, s10_a1_reg;
    logic [63:0] s11_n0_reg;
    logic [63:0] s13_den_reg;
    logic [63:0] q_reg    [80:83];
    bsc_side_t   side_reg [80:83];
    logic [63:0] b2_reg   [82:83];
    logic [63:0] s84_sum_reg;
    bsc_side_t   s84_side_reg;

    // multiplier and divider outputs (stage of arrival in the comment)
    logic [63:0] m_aa, m_ap5, m_ap2;      // stage 7
    logic [63:0] m_b6, m_a3;              // stage 9
    logic [63:0] m_den;                   // stage 12
    logic [63:0] m_num;                   // stage 13
    logic [63:0] q_div;                   // stage 79
    bsc_side_t   side_div;                // stage 79
    logic [63:0] m_ss, m_p8p;             // stage 81
    logic [63:0] m_p9;                    // stage 83

    // ---------------- stage logic ----------------
    logic [31:0] x_next, y_next;
    logic [31:0] s2_xt2_next, s2_yy_next;
    logic [31:0] s3_v1_next, s3_m_next;
    logic [31:0] s4_tf_next;
    logic [31:0] v_h;
    logic [63:0] s5_a_next;
    logic [31:0] s5_tc_next;
    logic [31:0] s5_h5v_next, s5_i1p_next, s5_i2p_next, s5_c_next;
    logic [31:0] s6_f1_next, s6_i1_next, s6_i2_next;
    logic [31:0] s7_i12_next;
    logic [31:0] s8_th2_next;
    logic [31:0] s9_f2_next;
    logic [31:0] s10_v2_next;
    logic [31:0] sv_h;
    logic [31:0] s11_ss_next;
    logic [31:0] s12_m_next;
    logic [31:0] hum_raw;
    logic [31:0] hum_clamped;
    logic [HUM_W-1:0] s13_hum_next;
    logic [63:0] s10_b_next, s10_a1_next;
    logic [63:0] s11_n0_next;
    logic [63:0] s13_den_next;
    logic [63:0] den_mul_a;
    logic [63:0] sh13;
    logic [63:0] s84_sum_next;
    bsc_side_t   div_side_in;

    always_comb
    begin
        // fine temperature
        x_next      = {15'b0, s1_rt_reg[19:3]} - {t1[30:0], 1'b0};
        y_next      = {16'b0, s1_rt_reg[19:4]} - t1;
        s2_xt2_next = x_next * t2;
        s2_yy_next  = y_next * y_next;
        s3_v1_next  = asr32(s2_xt2_reg, 11);
        s3_m_next   = asr32(s2_yy_reg, 12) * t3;
        s4_tf_next  = s3_v1_reg + asr32(s3_m_reg, 14);

        // temperature and the offsets for pressure and humidity
        s5_a_next   = sx32_64(tf_reg[4]) - T_OFFSET_P;
        s5_tc_next  = asr32((tf_reg[4] << 2) + tf_reg[4] + T_RND, 8);
        v_h         = tf_reg[4] - T_OFFSET_H;

        // humidity
        s5_h5v_next = h5 * v_h;
        s5_i1p_next = v_h * h6;
        s5_i2p_next = v_h * h3;
        s5_c_next   = {2'b0, rh_reg[4], 14'b0} - {h4[11:0], 20'b0} + H_RND_F1;
        s6_f1_next  = asr32(s5_c_reg - s5_h5v_reg, 15);
        s6_i1_next  = asr32(s5_i1p_reg, 10);
        s6_i2_next  = asr32(s5_i2p_reg, 11) + H_BIAS_I2;
        s7_i12_next = s6_i1_reg * s6_i2_reg;
        s8_th2_next = (asr32(s7_i12_reg, 10) + H_BIAS_F2) * h2;
        s9_f2_next  = asr32(s8_th2_reg + H_RND_F2, 14);
        s10_v2_next = f1_reg[9] * s9_f2_reg;
        sv_h        = asr32(s10_v2_reg, 15);
        s11_ss_next = sv_h * sv_h;
        s12_m_next  = asr32(s11_ss_reg, 7) * h1;
        hum_raw     = s12_v2_reg - asr32(s12_m_reg, 4);
        // clamp to 0..100 percent before dropping the low 12 bits
        if (hum_raw[31])
        begin
            hum_clamped = '0;
        end
        else if (hum_raw > HUM_MAX)
        begin
            hum_clamped = HUM_MAX;
        end
        else
        begin
            hum_clamped = hum_raw;
        end
        s13_hum_next = has_hum_reg ? hum_clamped[28:12] : '0;

        // pressure ahead of the division
        s10_b_next   = m_b6 + (ap5_reg[9] << 17) + (p4 << 35);
        s10_a1_next  = asr64(m_a3, 8) + (ap2_reg[9] << 12);
        den_mul_a    = P_ONE47 + s10_a1_reg;
        s11_n0_next  = ((P_BASE - {44'b0, rp_reg[10]}) << 31) - s10_b_reg;
        s13_den_next = asr64(m_den, 33);

        div_side_in.press_ok   = (s13_den_reg != '0);
        div_side_in.hum        = s13_hum_reg;
        div_side_in.temp_centi = tc_reg[13];
        div_side_in.fine       = tf_reg[13];

        // pressure after the division
        sh13         = asr64(q_div, 13);
        s84_sum_next = q_reg[83] + asr64(m_p9, 25) + b2_reg[83];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rp_reg[1]  <= s_axis_tdata[19:0];
            s1_rt_reg  <= s_axis_tdata[39:20];
            rh_reg[1]  <= s_axis_tdata[55:40];
            for (int k = 2; k <= 10; k++)
            begin
                rp_reg[k] <= rp_reg[k-1];
            end
            for (int k = 2; k <= 4; k++)
            begin
                rh_reg[k] <= rh_reg[k-1];
            end

            s2_xt2_reg <= s2_xt2_next;
            s2_yy_reg  <= s2_yy_next;
            s3_v1_reg  <= s3_v1_next;
            s3_m_reg   <= s3_m_next;
            tf_reg[4]  <= s4_tf_next;
            for (int k = 5; k <= 13; k++)
            begin
                tf_reg[k] <= tf_reg[k-1];
            end
            tc_reg[5] <= s5_tc_next;
            for (int k = 6; k <= 13; k++)
            begin
                tc_reg[k] <= tc_reg[k-1];
            end
            s5_a_reg   <= s5_a_next;

            s5_h5v_reg <= s5_h5v_next;
            s5_i1p_reg <= s5_i1p_next;
            s5_i2p_reg <= s5_i2p_next;
            s5_c_reg   <= s5_c_next;
            f1_reg[6]  <= s6_f1_next;
            for (int k = 7; k <= 9; k++)
            begin
                f1_reg[k] <= f1_reg[k-1];
            end
            s6_i1_reg   <= s6_i1_next;
            s6_i2_reg   <= s6_i2_next;
            s7_i12_reg  <= s7_i12_next;
            s8_th2_reg  <= s8_th2_next;
            s9_f2_reg   <= s9_f2_next;
            s10_v2_reg  <= s10_v2_next;
            s11_ss_reg  <= s11_ss_next;
            s11_v2_reg  <= s10_v2_reg;
            s12_m_reg   <= s12_m_next;
            s12_v2_reg  <= s11_v2_reg;
            s13_hum_reg <= s13_hum_next;

            ap5_reg[8]  <= m_ap5;
            ap5_reg[9]  <= ap5_reg[8];
            ap2_reg[8]  <= m_ap2;
            ap2_reg[9]  <= ap2_reg[8];
            s10_b_reg   <= s10_b_next;
            s10_a1_reg  <= s10_a1_next;
            s11_n0_reg  <= s11_n0_next;
            s13_den_reg <= s13_den_next;

            q_reg[80]    <= q_div;
            side_reg[80] <= side_div;
            for (int k = 81; k <= 83; k++)
            begin
                q_reg[k]    <= q_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
            b2_reg[82]   <= asr64(m_p8p, 19);
            b2_reg[83]   <= b2_reg[82];
            s84_sum_reg  <= s84_sum_next;
            s84_side_reg <= side_reg[83];
        end
    end

    // arithmetic units, each dedicated to one product or quotient
    bsc_mul64 u_mul_aa  (.clk(clk), .en(en), .a(s5_a_reg),   .b(s5_a_reg), .p(m_aa));
    bsc_mul64 u_mul_ap5 (.clk(clk), .en(en), .a(s5_a_reg),   .b(p5),       .p(m_ap5));
    bsc_mul64 u_mul_ap2 (.clk(clk), .en(en), .a(s5_a_reg),   .b(p2),       .p(m_ap2));
    bsc_mul64 u_mul_b6  (.clk(clk), .en(en), .a(m_aa),       .b(p6),       .p(m_b6));
    bsc_mul64 u_mul_a3  (.clk(clk), .en(en), .a(m_aa),       .b(p3),       .p(m_a3));
    bsc_mul64 u_mul_den (.clk(clk), .en(en), .a(den_mul_a),  .b(p1),       .p(m_den));
    bsc_mul64 u_mul_num (.clk(clk), .en(en), .a(s11_n0_reg), .b(P_SCALE),  .p(m_num));

    bsc_div64 u_div (
        .clk      (clk),
        .en       (en),
        .num      (m_num),
        .den      (s13_den_reg),
        .side_in  (div_side_in),
        .quot     (q_div),
        .side_out (side_div)
    );

    bsc_mul64 u_mul_ss  (.clk(clk), .en(en), .a(sh13),  .b(sh13),  .p(m_ss));
    bsc_mul64 u_mul_p8  (.clk(clk), .en(en), .a(p8),    .b(q_div), .p(m_p8p));
    bsc_mul64 u_mul_p9  (.clk(clk), .en(en), .a(p9),    .b(m_ss),  .p(m_p9));

    // ---------------- result assembly ----------------
    logic [63:0]            press_full;
    logic [31:0]            press_out;
    logic [OUT_TDATA_W-1:0] item_data;

    always_comb
    begin
        press_full = asr64(s84_sum_reg, 8) + (p7 << 4);
        // force pressure to zero when the divisor was zero
        press_out  = s84_side_reg.press_ok ? press_full[31:0] : '0;
        item_data  = {7'b0, s84_side_reg.hum, press_out,
                      s84_side_reg.temp_centi, s84_side_reg.fine};
    end

    // ---------------- output register with skid ----------------
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        out_from_skid   = 1'b0;
        if (out_valid_reg && !m_axis_tready)
        begin
            // hold the waiting result; park a newly finished one
            if (take)
            begin
                skid_valid_next = 1'b1;
                load_skid       = 1'b1;
            end
        end
        else if (skid_valid_reg)
        begin
            out_from_skid   = 1'b1;
            skid_valid_next = 1'b0;
            out_valid_next  = 1'b1;
        end
        else
        begin
            out_valid_next = take;
            load_out       = take;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_skid)
        begin
            skid_data_reg <= item_data;
            skid_user_reg <= s84_side_reg.press_ok;
        end
        if (out_from_skid)
        begin
            out_data_reg <= skid_data_reg;
            out_user_reg <= skid_user_reg;
        end
        else if (load_out)
        begin
            out_data_reg <= item_data;
            out_user_reg <= s84_side_reg.press_ok;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // ---------------- assertions ----------------
    `BSC_ASSERT(a_skid_needs_out, skid_valid_reg |-> out_valid_reg, "skid holds data while output is empty")
    `BSC_ASSERT(a_exit_lands, take |=> out_valid_reg, "result leaving the pipeline was lost")
    `BSC_ASSERT(a_bad_press_zero, (out_valid_reg && !out_user_reg) |-> (out_data_reg[95:64] == '0), "pressure not zeroed on bad divisor")
    `BSC_ASSERT(a_hum_range, out_valid_reg |-> (out_data_reg[112:96] <= HUM_OUT_MAX), "humidity above 100 percent")
    `BSC_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> (!out_valid_reg && !skid_valid_reg), "output not empty in reset")

endmodule

`default_nettype wire
